// ----- design/event_pair_correlation_table_core_macros.svh -----
// assertion macros for the event pair correlation table
`ifndef EVENT_PAIR_CORRELATION_TABLE_CORE_MACROS_SVH
`define EVENT_PAIR_CORRELATION_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define EPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("epct assertion failed");

// next-cycle implication
`define EPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("epct assertion failed");

`endif

// ----- design/epct_pkg.sv -----
// shared types, constants and helpers of the event pair correlation table
package epct_pkg;

  localparam int ENTRIES   = 256;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int ID_BITS   = 32;
  localparam int TIME_BITS = 48;
  localparam int WIN_W     = 40;
  localparam int MASK_W    = 32;

  localparam logic [5:0] MK_REMOTE  = 6'h01;
  localparam logic [5:0] MK_OUTSIDE = 6'h02;
  localparam logic [5:0] MK_NIEXEC  = 6'h04;
  localparam logic [5:0] MK_MEM     = 6'h08;
  localparam logic [5:0] MK_CTX     = 6'h10;
  localparam logic [5:0] MK_DUP     = 6'h20;

  typedef enum logic [2:0] {
    CFG_ENABLE   = 3'd0,
    CFG_WINDOW   = 3'd1,
    CFG_COOLDOWN = 3'd2,
    CFG_CTX_MASK = 3'd3,
    CFG_MEM_MASK = 3'd4,
    CFG_DUP_MASK = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]           marks;
    logic [31:0]          flags;
    logic [31:0]          access;
    logic [31:0]          age;
    logic [TIME_BITS-1:0] first;
    logic [TIME_BITS-1:0] last;
    logic [TIME_BITS-1:0] lmed;
    logic [TIME_BITS-1:0] lstr;
  } entry_t;

  typedef struct packed {
    logic                 live;
    logic                 done;
    logic                 hit;
    logic                 have;
    logic [IDX_W-1:0]     pick;
    logic [TIME_BITS-1:0] oldest;
    entry_t               ent;
  } carry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   actor;
    logic [ID_BITS-1:0]   target;
    logic [TIME_BITS-1:0] now;
    logic [WIN_W:0]       stale;
  } query_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [ID_BITS-1:0]   actor;
    logic [ID_BITS-1:0]   target;
    entry_t               ent;
  } wr_t;

  function automatic logic [TIME_BITS-1:0] since(input logic [TIME_BITS-1:0] now,
                                                  input logic [TIME_BITS-1:0] then_t);
    since = (now > then_t) ? (now - then_t) : '0;
  endfunction

endpackage

// ----- design/epct_cell.sv -----
// one table entry with its stage of the lookup chain
module epct_cell import epct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  query_t           query_i,
  input  wr_t              wr_i,
  input  carry_t           carry_i,
  output carry_t           carry_o
);

  logic               valid_q;
  logic [ID_BITS-1:0] actor_q, target_q;
  entry_t             ent_q;
  carry_t             carry_d, carry_q;
  logic               match, stale;

  assign match = (actor_q == query_i.actor) && (target_q == query_i.target);
  assign stale = since(query_i.now, ent_q.last) >
                 {{(TIME_BITS-WIN_W-1){1'b0}}, query_i.stale};

  always_comb begin
    carry_d = carry_i;
    if (carry_i.live && !carry_i.done) begin
      if (!valid_q) begin
        carry_d.done = 1'b1;
        carry_d.hit  = 1'b0;
        carry_d.pick = idx_i;
      end else if (match) begin
        carry_d.done = 1'b1;
        carry_d.hit  = 1'b1;
        carry_d.pick = idx_i;
        carry_d.ent  = ent_q;
      end else if (stale) begin
        carry_d.done = 1'b1;
        carry_d.hit  = 1'b0;
        carry_d.pick = idx_i;
      end else if (!carry_i.have || (ent_q.last < carry_i.oldest)) begin
        carry_d.have   = 1'b1;
        carry_d.oldest = ent_q.last;
        carry_d.pick   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      valid_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
      if (wr_i.en && (wr_i.idx == idx_i)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      actor_q  <= wr_i.actor;
      target_q <= wr_i.target;
      ent_q    <= wr_i.ent;
    end
  end

  assign carry_o = carry_q;

endmodule

// ----- design/event_pair_correlation_table_core.sv -----
// Thread observation correlator. An item with a zero target gives no result. An item that
// leaves the table alone (disabled, or no mark bit) gives its result in the cycle after it is
// taken. An item that updates the table runs its lookup down the chain of ENTRIES entry
// cells, one cell per cycle, then merges and checks alerts in the merge and alert states.
// busy is high meanwhile. Each result is on the ports for one cycle under result_valid_o
// and cannot be held off. The table is empty right after reset; configuration writes are
// always accepted.
module event_pair_correlation_table_core import epct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [WIN_W-1:0]     cfg_data_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [ID_BITS-1:0]   target_id_i,
  input  logic [ID_BITS-1:0]   actor_id_i,
  input  logic                 outside_image_i,
  input  logic                 got_start_i,
  input  logic                 start_exec_i,
  input  logic                 start_non_image_i,
  input  logic [31:0]          intent_flags_i,
  input  logic [31:0]          access_bits_i,
  input  logic [31:0]          intent_age_ms_i,
  input  logic [TIME_BITS-1:0] now_ticks_i,
  output logic                 result_valid_o,
  output logic [6:0]           rule_bits_o,
  output logic [1:0]           chain_level_o,
  output logic [ID_BITS-1:0]   resolved_actor_o,
  output logic [31:0]          chain_flags_o,
  output logic [31:0]          chain_access_o,
  output logic [31:0]          chain_age_ms_o
);

  `include "event_pair_correlation_table_core_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_ALERT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic              enable_q;
  logic [WIN_W-1:0]  window_q, cooldown_q;
  logic [MASK_W-1:0] ctx_mask_q, mem_mask_q, dup_mask_q;

  logic [ID_BITS-1:0]   actor_q, target_q;
  logic [TIME_BITS-1:0] now_q;
  logic [31:0]          flags_q, access_q, age_q;
  logic [5:0]           marks_q;
  logic                 launch_q;
  entry_t               m_q;
  logic                 expired_q;
  logic [IDX_W-1:0]     pick_q;

  logic                 accept;
  logic [ID_BITS-1:0]   actor;
  logic                 remote, rne, tc, mem, dup, sus;
  logic [6:0]           rules;
  logic [5:0]           marks;

  query_t query;
  wr_t    wr;
  carry_t carry_in;
  carry_t chain [ENTRIES];

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  assign actor  = (actor_id_i == '0) ? target_id_i : actor_id_i;
  assign remote = (actor != target_id_i);
  assign rne    = remote && got_start_i && start_exec_i && start_non_image_i;
  assign tc     = (intent_flags_i & ctx_mask_q) != '0;
  assign mem    = (intent_flags_i & mem_mask_q) != '0;
  assign dup    = (intent_flags_i & dup_mask_q) != '0;
  assign sus    = outside_image_i || rne;

  always_comb begin
    rules    = '0;
    rules[0] = remote && (intent_flags_i != '0);
    rules[1] = rne;
    rules[2] = remote && outside_image_i;
    rules[3] = tc && (remote || outside_image_i || rne);
    rules[4] = remote && tc && sus;
    rules[5] = remote && sus && mem && (tc || dup);
    rules[6] = remote && sus && (mem || dup);
    marks    = '0;
    if (remote)          marks = marks | MK_REMOTE;
    if (outside_image_i) marks = marks | MK_OUTSIDE;
    if (rne)             marks = marks | MK_NIEXEC;
    if (mem)             marks = marks | MK_MEM;
    if (tc)              marks = marks | MK_CTX;
    if (dup)             marks = marks | MK_DUP;
  end

  assign query.actor  = actor_q;
  assign query.target = target_q;
  assign query.now    = now_q;
  assign query.stale  = {window_q, 1'b0};

  always_comb begin
    carry_in      = '0;
    carry_in.live = launch_q;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    epct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(i)),
      .query_i (query),
      .wr_i    (wr),
      .carry_i ((i == 0) ? carry_in : chain[(i == 0) ? 0 : i - 1]),
      .carry_o (chain[i])
    );
  end

  // merge the found or fresh entry with this item
  carry_t tail, tail_q;
  entry_t base, merged;
  assign tail = chain[ENTRIES-1];

  always_comb begin
    if (tail_q.hit) begin
      base = tail_q.ent;
    end else begin
      base       = '0;
      base.first = now_q;
      base.last  = now_q;
    end
    merged        = base;
    merged.marks  = base.marks | marks_q;
    merged.flags  = base.flags | flags_q;
    merged.access = base.access | access_q;
    if (age_q != '0) merged.age = age_q;
    merged.last   = now_q;
    if (base.first == '0) merged.first = now_q;
  end

  // alert check and final entry
  entry_t fin;
  logic [1:0] level;
  logic hr, hs, hm, hc, hd, med_hit, str_hit, cool_s, cool_m;

  assign hr      = (m_q.marks & MK_REMOTE) != '0;
  assign hs      = (m_q.marks & (MK_OUTSIDE | MK_NIEXEC)) != '0;
  assign hm      = (m_q.marks & MK_MEM) != '0;
  assign hc      = (m_q.marks & MK_CTX) != '0;
  assign hd      = (m_q.marks & MK_DUP) != '0;
  assign med_hit = hr && hs && (hm || hc || hd);
  assign str_hit = hr && hs && hm && (hc || hd);
  assign cool_s = (m_q.lstr == '0) ||
                  (since(now_q, m_q.lstr) >= {{(TIME_BITS-WIN_W){1'b0}}, cooldown_q});
  assign cool_m = (m_q.lmed == '0) ||
                  (since(now_q, m_q.lmed) >= {{(TIME_BITS-WIN_W){1'b0}}, cooldown_q});

  always_comb begin
    fin   = m_q;
    level = 2'd0;
    if (expired_q) begin
      fin.marks  = '0;
      fin.flags  = '0;
      fin.access = '0;
      fin.age    = '0;
      fin.first  = now_q;
    end else if (str_hit && cool_s) begin
      fin.lstr = now_q;
      level    = 2'd2;
    end else if (med_hit && cool_m) begin
      fin.lmed = now_q;
      level    = 2'd1;
    end
  end

  always_comb begin
    wr        = '0;
    wr.en     = (state_q == ST_ALERT);
    wr.idx    = pick_q;
    wr.actor  = actor_q;
    wr.target = target_q;
    wr.ent    = fin;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (target_id_i != '0) && (marks != '0) && enable_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.live) state_d = ST_MERGE;
      end
      ST_MERGE: state_d = ST_ALERT;
      ST_ALERT: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      launch_q       <= 1'b0;
      result_valid_o <= 1'b0;
      enable_q       <= 1'b1;
      window_q       <= WIN_W'(30000);
      cooldown_q     <= WIN_W'(3000);
      ctx_mask_q     <= 32'h0000_0001;
      mem_mask_q     <= 32'h0000_0002;
      dup_mask_q     <= 32'h0000_0004;
    end else begin
      state_q        <= state_d;
      launch_q       <= (state_q == ST_IDLE) && (state_d == ST_SCAN);
      result_valid_o <= (accept && (target_id_i != '0) && (state_d == ST_IDLE)) ||
                        (state_q == ST_ALERT);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENABLE:   enable_q   <= cfg_data_i[0];
          CFG_WINDOW:   window_q   <= cfg_data_i;
          CFG_COOLDOWN: cooldown_q <= cfg_data_i;
          CFG_CTX_MASK: ctx_mask_q <= cfg_data_i[MASK_W-1:0];
          CFG_MEM_MASK: mem_mask_q <= cfg_data_i[MASK_W-1:0];
          CFG_DUP_MASK: dup_mask_q <= cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      actor_q          <= actor;
      target_q         <= target_id_i;
      now_q            <= now_ticks_i;
      flags_q          <= intent_flags_i;
      access_q         <= access_bits_i;
      age_q            <= intent_age_ms_i;
      marks_q          <= marks;
      rule_bits_o      <= rules;
      resolved_actor_o <= actor;
      chain_level_o    <= 2'd0;
      chain_flags_o    <= '0;
      chain_access_o   <= '0;
      chain_age_ms_o   <= '0;
    end
    if ((state_q == ST_SCAN) && tail.live) begin
      tail_q <= tail;
    end
    if (state_q == ST_MERGE) begin
      m_q       <= merged;
      expired_q <= since(now_q, merged.first) > {{(TIME_BITS-WIN_W){1'b0}}, window_q};
      pick_q    <= tail_q.pick;
    end
    if (state_q == ST_ALERT) begin
      chain_level_o  <= level;
      chain_flags_o  <= (level != 2'd0) ? fin.flags : '0;
      chain_access_o <= (level != 2'd0) ? fin.access : '0;
      chain_age_ms_o <= (level != 2'd0) ? fin.age : '0;
    end
  end

  `EPCT_ASSERT_NOW(a_level_range, result_valid_o, chain_level_o != 2'd3)
  `EPCT_ASSERT_NOW(a_quiet_fields, result_valid_o && (chain_level_o == 2'd0),
    (chain_flags_o == '0) && (chain_access_o == '0) && (chain_age_ms_o == '0))
  `EPCT_ASSERT_NEXT(a_scan_done, (state_q == ST_SCAN) && tail.live, state_q == ST_MERGE)
  `EPCT_ASSERT_NEXT(a_alert_emits, state_q == ST_ALERT, result_valid_o)

endmodule
